FILE: rtl/pool_and_concurrency_admission_defines.svh
// Assertion macros for the pool and concurrency admission block.
// Used by files that hold concurrent checks; they expect clk and rst_n in scope.
`ifndef POOL_AND_CONCURRENCY_ADMISSION_DEFINES_SVH
`define POOL_AND_CONCURRENCY_ADMISSION_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pca_pkg.sv
// Shared constants, codes and types of the pool and concurrency admission block.
// No dependencies; used by every module in rtl.
package pca_pkg;

    localparam int NUM_POOLS = 4;
    localparam int NUM_KINDS = 4;
    localparam int AMT_LANES = 4;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 104;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_TOTALS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_RESERVED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_LIMITS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_DECLARED = 2'd3;

    localparam logic ACT_ADMIT   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNDECLARED = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [2:0] ST_LIMIT      = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd4;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef logic [NUM_POOLS-1:0][15:0] pool_vec_t;
    typedef logic [NUM_KINDS-1:0][15:0] kind_vec_t;
    typedef logic [AMT_LANES-1:0][15:0] lane_vec_t;

    typedef struct packed {
        pool_vec_t              totals;
        pool_vec_t              reserved;
        kind_vec_t              limits;
        logic [NUM_POOLS-1:0]   declared;
    } cfg_t;

    typedef struct packed {
        logic       action;
        logic [1:0] task_kind;
        logic [3:0] pool_mask;
        lane_vec_t  amount;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  fail_pool;
        lane_vec_t   in_use;
        logic [15:0] kind_in_flight;
        logic [17:0] total_in_flight;
    } result_t;

    typedef struct packed {
        result_t   res;
        pool_vec_t pool_next;
        kind_vec_t kind_next;
    } decision_t;

endpackage

FILE: rtl/pca_cfg_regs.sv
// Configuration register file: pool totals, reservations, type limits, declared pools.
// Depends on pca_pkg.
module pca_cfg_regs
    import pca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POOL_TOTALS:
                begin
                    for (int i = 0; i < NUM_POOLS; i++)
                        cfg_reg.totals[i] <= cfg_data[16*i +: 16];
                end
                REG_POOL_RESERVED:
                begin
                    for (int i = 0; i < NUM_POOLS; i++)
                        cfg_reg.reserved[i] <= cfg_data[16*i +: 16];
                end
                REG_TYPE_LIMITS:
                begin
                    for (int i = 0; i < NUM_KINDS; i++)
                        cfg_reg.limits[i] <= cfg_data[16*i +: 16];
                end
                REG_POOL_DECLARED:
                begin
                    cfg_reg.declared <= cfg_data[NUM_POOLS-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/pca_decide.sv
// Admission decision: pool checks in index order, concurrency check, counter updates.
// Pure combinational logic between the input register and the result register; uses pca_pkg.
module pca_decide
    import pca_pkg::*;
(
    input  cfg_t      cfg,
    input  item_t     item,
    input  pool_vec_t pool_use,
    input  kind_vec_t kind_run,
    output decision_t dec
);

    pool_vec_t   free_space;
    logic [16:0] taken;
    logic [16:0] sum;
    logic        found;
    logic [15:0] run;
    logic [15:0] lim;
    logic [17:0] total;

    // Shared free space per pool, floored at zero
    always_comb
    begin
        taken = '0;
        for (int i = 0; i < NUM_POOLS; i++)
        begin
            taken = {1'b0, cfg.reserved[i]} + {1'b0, pool_use[i]};
            free_space[i] = ({1'b0, cfg.totals[i]} > taken) ?
                            (cfg.totals[i] - taken[15:0]) : 16'd0;
        end
    end

    always_comb
    begin
        dec = '0;
        dec.pool_next = pool_use;
        dec.kind_next = kind_run;
        dec.res.status = ST_OK;
        dec.res.fail_pool = '0;
        found = 1'b0;
        sum = '0;
        total = '0;
        run = (32'(item.task_kind) < NUM_KINDS) ? kind_run[item.task_kind] : 16'd0;
        lim = (32'(item.task_kind) < NUM_KINDS) ? cfg.limits[item.task_kind] : 16'd0;

        if (item.action == ACT_ADMIT)
        begin
            // first failing pool decides the status
            for (int i = 0; i < AMT_LANES; i++)
            begin
                if (!found && item.pool_mask[i])
                begin
                    if (i >= NUM_POOLS || !cfg.declared[i])
                    begin
                        dec.res.status = ST_UNDECLARED;
                        dec.res.fail_pool = 2'(i);
                        found = 1'b1;
                    end
                    else if (item.amount[i] > free_space[i])
                    begin
                        dec.res.status = ST_EXHAUSTED;
                        dec.res.fail_pool = 2'(i);
                        found = 1'b1;
                    end
                end
            end
            if (!found)
            begin
                if (32'(item.task_kind) >= NUM_KINDS || (lim != 16'd0 && run >= lim) ||
                    run == CNT_MAX)
                begin
                    dec.res.status = ST_LIMIT;
                end
                else
                begin
                    for (int i = 0; i < NUM_POOLS; i++)
                    begin
                        if (item.pool_mask[i])
                        begin
                            sum = {1'b0, pool_use[i]} + {1'b0, item.amount[i]};
                            dec.pool_next[i] = sum[16] ? CNT_MAX : sum[15:0];
                        end
                    end
                    dec.kind_next[item.task_kind] = run + 16'd1;
                end
            end
        end
        else
        begin
            // release: drain the named pools even when the type count underflows
            for (int i = 0; i < NUM_POOLS; i++)
            begin
                if (item.pool_mask[i])
                    dec.pool_next[i] = (item.amount[i] >= pool_use[i]) ? 16'd0 :
                                       (pool_use[i] - item.amount[i]);
            end
            if (32'(item.task_kind) >= NUM_KINDS || run == 16'd0)
                dec.res.status = ST_UNDERFLOW;
            else
                dec.kind_next[item.task_kind] = run - 16'd1;
        end

        for (int i = 0; i < AMT_LANES; i++)
            dec.res.in_use[i] = (i < NUM_POOLS) ? dec.pool_next[i] : 16'd0;
        dec.res.kind_in_flight = (32'(item.task_kind) < NUM_KINDS) ?
                                 dec.kind_next[item.task_kind] : 16'd0;
        for (int i = 0; i < NUM_KINDS; i++)
            total = total + {2'b00, dec.kind_next[i]};
        dec.res.total_in_flight = total;
    end

endmodule

FILE: rtl/pool_and_concurrency_admission.sv
// Top level of the pool and concurrency admission block.
// Instantiates pca_cfg_regs and pca_decide; uses pca_pkg and the assertion macro header.
//
// Usage:
//   The slave stream (s_tvalid/s_tready/s_tdata/s_tuser) carries admit and
//   release requests; s_tuser is the action (0 admit, 1 release). The master
//   stream (m_tvalid/m_tready/m_tdata) returns exactly one result per request,
//   in order. The cfg_we/cfg_index/cfg_data port writes the four setup
//   registers (totals, reservations, type limits, declared mask); write it
//   only while no request is in flight.
//   A request accepted into the input register is decided once the result
//   register is free or draining; the result register then drives m_tvalid.
//   Throughput: one request per cycle while m_tready stays high, set by the
//   loop through the pool and type counters that each decision reads and updates.
//   Reset clears the counters, the setup registers and both stream valid flags.
//   When m_tready is low the result holds; one more request is buffered in
//   the input register, after which s_tready drops until the result is taken.
`include "pool_and_concurrency_admission_defines.svh"

module pool_and_concurrency_admission
    import pca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // task_kind[1:0], pool_mask[5:2], amount_pool0[21:6], amount_pool1[37:22],
    // amount_pool2[53:38], amount_pool3[69:54], zero fill above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[2:0], fail_pool[4:3], in_use_pool0[20:5], in_use_pool1[36:21],
    // in_use_pool2[52:37], in_use_pool3[68:53], kind_in_flight[84:69],
    // total_in_flight[102:85], zero fill above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cfg_t      cfg;
    item_t     in_item;
    item_t     in_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    result_t   out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    pool_vec_t pool_use_reg;
    kind_vec_t kind_run_reg;
    decision_t dec;
    logic      s_accept;
    logic      fire;

    pca_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pca_decide u_decide (
        .cfg      (cfg),
        .item     (in_reg),
        .pool_use (pool_use_reg),
        .kind_run (kind_run_reg),
        .dec      (dec)
    );

    always_comb
    begin
        in_item.action    = s_tuser;
        in_item.task_kind = s_tdata[1:0];
        in_item.pool_mask = s_tdata[5:2];
        for (int i = 0; i < AMT_LANES; i++)
            in_item.amount[i] = s_tdata[6 + 16*i +: 16];
    end

    // decide when a request waits and the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pool_use_reg  <= '0;
            kind_run_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                pool_use_reg <= dec.pool_next;
                kind_run_reg <= dec.kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_reg <= in_item;
        if (fire)
            out_reg <= dec.res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.total_in_flight, out_reg.kind_in_flight,
                       out_reg.in_use[3], out_reg.in_use[2], out_reg.in_use[1],
                       out_reg.in_use[0], out_reg.fail_pool, out_reg.status};

    `PCA_ASSERT_NEXT(a_fire_loads_result, fire, m_tvalid, "decided request left no result")
    `PCA_ASSERT_NEXT(a_refused_admit_holds_counters,
        fire && in_reg.action == ACT_ADMIT && dec.res.status != ST_OK,
        $stable(pool_use_reg) && $stable(kind_run_reg), "refused admit changed counters")
    `PCA_ASSERT_SAME(a_stall_only_when_full, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready, "input stalled with room to spare")
    `PCA_ASSERT_SAME(a_fail_pool_only_on_pool_fault,
        out_valid_reg && out_reg.fail_pool != 2'd0,
        out_reg.status == ST_UNDECLARED || out_reg.status == ST_EXHAUSTED,
        "fail_pool set without a pool fault")
    `PCA_ASSERT_SAME(a_underflow_reports_zero,
        out_valid_reg && out_reg.status == ST_UNDERFLOW,
        out_reg.kind_in_flight == 16'd0, "underflow with nonzero type count")

endmodule

FILE: sim/pca_admission_check.sv
`timescale 1ns / 1ps
// Scoreboard for the pool and concurrency admission block: mirrors the setup registers,
// predicts one verdict per accepted request and compares it with each result transfer.
// Depends on pca_pkg only.
module pca_admission_check
    import pca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    errors,
    output int                    verdicts_owed
);

    pool_vec_t            totals;
    pool_vec_t            reserved;
    kind_vec_t            limits;
    logic [NUM_POOLS-1:0] declared;
    pool_vec_t            in_use;
    kind_vec_t            running;

    result_t              verdict_q[$];
    item_t                req_in;
    result_t              got;
    result_t              want;

    task automatic report(string what, int unsigned got_v, int unsigned want_v);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got_v, want_v, $realtime);
        errors++;
    endtask

    // Free space left to share: total minus reserved minus in use, floored at zero.
    function automatic logic [15:0] pool_headroom(int p);
        logic [16:0] taken;
        taken = {1'b0, reserved[p]} + {1'b0, in_use[p]};
        return ({1'b0, totals[p]} > taken) ? (totals[p] - taken[15:0]) : 16'd0;
    endfunction

    function automatic result_t decide_request(item_t it);
        result_t     r;
        logic [16:0] sum;
        logic [17:0] total;
        int          k;
        r = '0;
        r.status = ST_OK;
        k = it.task_kind;
        if (it.action == ACT_ADMIT) begin
            // The first failing pool in index order decides the status.
            for (int i = 0; i < AMT_LANES; i++) begin
                if (r.status == ST_OK && it.pool_mask[i]) begin
                    if (i >= NUM_POOLS || !declared[i]) begin
                        r.status    = ST_UNDECLARED;
                        r.fail_pool = i[1:0];
                    end
                    else if (it.amount[i] > pool_headroom(i)) begin
                        r.status    = ST_EXHAUSTED;
                        r.fail_pool = i[1:0];
                    end
                end
            end
            if (r.status == ST_OK) begin
                if (k >= NUM_KINDS)
                    r.status = ST_LIMIT;
                else if ((limits[k] != 16'd0 && running[k] >= limits[k]) || running[k] == CNT_MAX)
                    r.status = ST_LIMIT;
            end
            if (r.status == ST_OK) begin
                for (int i = 0; i < NUM_POOLS; i++) begin
                    if (it.pool_mask[i]) begin
                        sum       = {1'b0, in_use[i]} + {1'b0, it.amount[i]};
                        in_use[i] = sum[16] ? CNT_MAX : sum[15:0];
                    end
                end
                running[k] = running[k] + 16'd1;
            end
        end
        else begin
            // Subtract even on underflow, whether or not the pool is declared.
            for (int i = 0; i < NUM_POOLS; i++) begin
                if (it.pool_mask[i])
                    in_use[i] = (it.amount[i] >= in_use[i]) ? 16'd0 : in_use[i] - it.amount[i];
            end
            if (k >= NUM_KINDS || running[k] == 16'd0)
                r.status = ST_UNDERFLOW;
            else
                running[k] = running[k] - 16'd1;
        end
        for (int i = 0; i < AMT_LANES; i++)
            r.in_use[i] = (i < NUM_POOLS) ? in_use[i] : 16'd0;
        r.kind_in_flight = (k < NUM_KINDS) ? running[k] : 16'd0;
        total = '0;
        for (int i = 0; i < NUM_KINDS; i++)
            total = total + {2'b00, running[i]};
        r.total_in_flight = total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            totals   = '0;
            reserved = '0;
            limits   = '0;
            declared = '0;
            in_use   = '0;
            running  = '0;
            errors   = 0;
            verdict_q.delete();
            verdicts_owed <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_POOL_TOTALS:   totals   = cfg_data;
                    REG_POOL_RESERVED: reserved = cfg_data;
                    REG_TYPE_LIMITS:   limits   = cfg_data;
                    REG_POOL_DECLARED: declared = cfg_data[NUM_POOLS-1:0];
                    default: ;
                endcase
            end
            // Retire before predicting so a result never pairs with a request of the same edge.
            if (m_tvalid && m_tready) begin
                got.status          = m_tdata[2:0];
                got.fail_pool       = m_tdata[4:3];
                got.in_use          = m_tdata[68:5];
                got.kind_in_flight  = m_tdata[84:69];
                got.total_in_flight = m_tdata[102:85];
                if (verdict_q.size() == 0) begin
                    report("transfer with no pending request, status", got.status, 0);
                end
                else begin
                    want = verdict_q.pop_front();
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                    if (got.fail_pool != want.fail_pool)
                        report("fail_pool", got.fail_pool, want.fail_pool);
                    for (int i = 0; i < AMT_LANES; i++) begin
                        if (got.in_use[i] != want.in_use[i])
                            report($sformatf("in_use_pool%0d", i), got.in_use[i], want.in_use[i]);
                    end
                    if (got.kind_in_flight != want.kind_in_flight)
                        report("kind_in_flight", got.kind_in_flight, want.kind_in_flight);
                    if (got.total_in_flight != want.total_in_flight)
                        report("total_in_flight", got.total_in_flight, want.total_in_flight);
                end
            end
            if (s_tvalid && s_tready) begin
                req_in.action    = s_tuser;
                req_in.task_kind = s_tdata[1:0];
                req_in.pool_mask = s_tdata[5:2];
                req_in.amount    = s_tdata[69:6];
                verdict_q.push_back(decide_request(req_in));
            end
            verdicts_owed <= verdict_q.size();
        end
    end

endmodule

FILE: sim/pool_and_concurrency_admission_test.sv
`timescale 1ns / 1ps
// Top of the admission block test: clock, reset, setup writes, request and result stalls.
// Instantiates pool_and_concurrency_admission and pca_admission_check; uses pca_pkg.
module pool_and_concurrency_admission_test;
    import pca_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 140;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    errors;
    int                    verdicts_owed;

    bit                    quiet = 1'b0;
    logic [63:0]           tot_cfg;
    logic [3:0]            decl_cfg;
    int                    idle_cycles;

    pool_and_concurrency_admission u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pca_admission_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .errors        (errors),
        .verdicts_owed (verdicts_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t make_req(logic act, logic [1:0] kind, logic [3:0] mask,
                                       logic [15:0] a0, logic [15:0] a1,
                                       logic [15:0] a2, logic [15:0] a3);
        item_t it;
        it.action    = act;
        it.task_kind = kind;
        it.pool_mask = mask;
        it.amount    = {a3, a2, a1, a0};
        return it;
    endfunction

    // Mostly declared pools with amounts scaled to the capacity; one in ten is raw noise.
    function automatic item_t random_req();
        item_t it;
        int    scale;
        int    pick;
        it.action    = ($urandom_range(0, 99) < 55) ? ACT_ADMIT : ACT_RELEASE;
        it.task_kind = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) begin
            it.pool_mask = $urandom_range(0, 15);
            for (int i = 0; i < AMT_LANES; i++)
                it.amount[i] = $urandom_range(0, 65535);
        end
        else begin
            it.pool_mask = $urandom_range(1, 15) & decl_cfg;
            if (it.pool_mask == 4'd0)
                it.pool_mask = $urandom_range(0, 15);
            for (int i = 0; i < AMT_LANES; i++) begin
                scale = tot_cfg[16*i +: 16] / 6 + 1;
                pick  = $urandom_range(0, 19);
                if (pick == 0)
                    it.amount[i] = 16'd0;
                else if (pick == 1)
                    it.amount[i] = 16'hFFFF;
                else
                    it.amount[i] = $urandom_range(0, scale);
            end
        end
        return it;
    endfunction

    task automatic write_setup(input logic [63:0] tot, input logic [63:0] res,
                               input logic [63:0] lim, input logic [63:0] decl);
        logic [63:0]          vals [4];
        logic [CFG_IDX_W-1:0] idx  [4];
        vals = '{tot, res, lim, decl};
        idx  = '{REG_POOL_TOTALS, REG_POOL_RESERVED, REG_TYPE_LIMITS, REG_POOL_DECLARED};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        tot_cfg  = tot;
        decl_cfg = decl[3:0];
    endtask

    task automatic send_req(input item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-70){1'b0}}, it.amount, it.pool_mask, it.task_kind};
        s_tuser  <= it.action;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid, wait for every verdict, then let the result register settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (verdicts_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    // Result side: a fresh stall before each transfer.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [63:0] tot;
        logic [63:0] res;
        logic [63:0] lim;
        logic [63:0] decl;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        tot_cfg   = '0;
        decl_cfg  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pool 2 has more reserved than total, pool 3 is undeclared.
        write_setup({16'hFFFF, 16'd10, 16'd200, 16'd1000},
                    {16'd0, 16'd20, 16'd50, 16'd0},
                    {16'd0, 16'hFFFF, 16'd2, 16'd1},
                    64'h7);
        send_req(make_req(ACT_RELEASE, 2'd0, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd0, 4'b0001, 16'd1000, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd1, 4'b0001, 16'd1, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd0, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd1, 4'b1000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd1, 4'b1010, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd1, 4'b0110, 16'd0, 16'd999, 16'd5, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd1, 4'b0100, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd1, 4'b0100, 16'd0, 16'd0, 16'd1, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd1, 4'b0010, 16'd0, 16'd150, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd1, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_RELEASE, 2'd1, 4'b0011, 16'hFFFF, 16'd10, 16'd0, 16'd0));
        send_req(make_req(ACT_RELEASE, 2'd2, 4'b1111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(ACT_ADMIT,   2'd2, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd3, 4'b0011, 16'd1000, 16'd10, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd3, 4'b0010, 16'd0, 16'd1, 16'd0, 16'd0));
        send_req(make_req(ACT_RELEASE, 2'd3, 4'b1111, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(ACT_RELEASE, 2'd3, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd2, 4'b0001, 16'hFFFF, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_RELEASE, 2'd0, 4'b0001, 16'd0, 16'd0, 16'd0, 16'd0));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                tot  = {4{16'hFFFF}};
                res  = '0;
                lim  = '0;
                decl = 64'hF;
            end
            else if (ph == 1) begin
                tot  = '0;
                res  = {4{16'hFFFF}};
                lim  = {4{16'hFFFF}};
                decl = {{60{1'b1}}, 4'hF};
            end
            else begin
                for (int i = 0; i < 4; i++) begin
                    tot[16*i +: 16] = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                                  : $urandom_range(0, 3000);
                    res[16*i +: 16] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                                  : $urandom_range(0, tot[16*i +: 16] / 3);
                    lim[16*i +: 16] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                decl      = {$urandom, $urandom};
                decl[3:0] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 4'hF;
            end
            write_setup(tot, res, lim, decl);
            quiet = (ph == 3 || ph == 6);
            repeat (PHASE_ITEMS) send_req(random_req());
            drain();
        end

        // Step type 3 back and forth across a limit of two.
        write_setup({4{16'hFFFF}}, '0, {16'd2, 48'd0}, 64'hF);
        quiet = 1'b1;
        send_req(make_req(ACT_ADMIT,   2'd3, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd3, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd3, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_RELEASE, 2'd3, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd3, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ADMIT,   2'd3, 4'b0000, 16'd0, 16'd0, 16'd0, 16'd0));
        quiet = 1'b0;
        drain();

        if (errors == 0 && verdicts_owed == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
